@@ sv/qte_pkg.sv @@
// Shared widths, types and the arctangent table for the quaternion to Euler block.
`timescale 1ns / 1ps
package qte_pkg;
	localparam int QW         = 16;  // quaternion component width
	localparam int PW         = 32;  // product width
	localparam int XW         = 38;  // CORDIC x/y width, covers gain and growth
	localparam int ZW         = 32;  // angle accumulator, 2^-16 cdeg
	localparam int SW         = 30;  // clamped pitch term, Q28
	localparam int VW         = 57;  // radicand, up to 2^56
	localparam int RW         = 58;  // root accumulator
	localparam int STEPS      = 28;
	localparam int ROOT_STEPS = 29;

	localparam logic signed [ZW-1:0] QUARTER_TURN = 32'sd589824000;
	localparam logic signed [XW-1:0] ONE_Q28      = 38'sd268435456;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	typedef struct packed {
		logic signed [XW-1:0] sr;
		logic signed [XW-1:0] cr;
		logic signed [XW-1:0] sy;
		logic signed [XW-1:0] cy;
		logic signed [SW-1:0] sp;
	} args_t;

	// atan(2^-n) in 2^-16 cdeg
	function automatic logic signed [ZW-1:0] arc(input int n);
		logic signed [ZW-1:0] a;
		unique case (n)
			0:  a = 32'sd294912000;
			1:  a = 32'sd174096719;
			2:  a = 32'sd91987925;
			3:  a = 32'sd46694507;
			4:  a = 32'sd23437865;
			5:  a = 32'sd11729858;
			6:  a = 32'sd5866610;
			7:  a = 32'sd2933484;
			8:  a = 32'sd1466766;
			9:  a = 32'sd733385;
			10: a = 32'sd366693;
			11: a = 32'sd183347;
			12: a = 32'sd91673;
			13: a = 32'sd45837;
			14: a = 32'sd22918;
			15: a = 32'sd11459;
			16: a = 32'sd5730;
			17: a = 32'sd2865;
			18: a = 32'sd1432;
			19: a = 32'sd716;
			20: a = 32'sd358;
			21: a = 32'sd179;
			22: a = 32'sd90;
			23: a = 32'sd45;
			24: a = 32'sd22;
			25: a = 32'sd11;
			26: a = 32'sd6;
			27: a = 32'sd3;
			default: a = '0;
		endcase
		return a;
	endfunction

	// Move a left-half vector into the right half by a quarter turn.
	function automatic cordic_t pre_rotate(input logic signed [XW-1:0] y,
			input logic signed [XW-1:0] x);
		cordic_t c;
		c.x = x;
		c.y = y;
		c.z = '0;
		if (x < 0) begin
			if (y >= 0) begin
				c.x = y;
				c.y = -x;
				c.z = QUARTER_TURN;
			end else begin
				c.x = -y;
				c.y = x;
				c.z = -QUARTER_TURN;
			end
		end
		return c;
	endfunction
endpackage

@@ sv/qte_in_if.sv @@
// Input channel: one quaternion per transaction.
`timescale 1ns / 1ps
interface qte_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] q_real;
	logic signed [15:0] q_i;
	logic signed [15:0] q_j;
	logic signed [15:0] q_k;
	modport source (output valid, q_real, q_i, q_j, q_k, input ready);
	modport sink (input valid, q_real, q_i, q_j, q_k, output ready);
endinterface

@@ sv/qte_out_if.sv @@
// Output channel: roll, pitch and yaw per transaction.
`timescale 1ns / 1ps
interface qte_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] roll_cdeg;
	logic signed [14:0] pitch_cdeg;
	logic        [15:0] yaw_cdeg;
	modport source (output valid, roll_cdeg, pitch_cdeg, yaw_cdeg, input ready);
	modport sink (input valid, roll_cdeg, pitch_cdeg, yaw_cdeg, output ready);
endinterface

@@ sv/qte_root_cell.sv @@
// One bit step of the pipelined integer square root.
`timescale 1ns / 1ps
module qte_root_cell import qte_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [VW-1:0] v_in,
	input  logic [RW-1:0] r_in,
	output logic [VW-1:0] v_out,
	output logic [RW-1:0] r_out
);
	localparam logic [RW:0] BIT = (RW+1)'(1) << (2 * (ROOT_STEPS - 1 - STEP));

	logic [RW:0] trial;
	assign trial = {1'b0, r_in} + BIT;

	always_ff @(posedge clk) begin
		if (en) begin
			if ({2'b0, v_in} >= trial) begin
				v_out <= VW'({2'b0, v_in} - trial);
				r_out <= RW'((r_in >> 1) + BIT);
			end else begin
				v_out <= v_in;
				r_out <= r_in >> 1;
			end
		end
	end
endmodule

@@ sv/qte_cordic_cell.sv @@
// One vectoring micro-rotation of the CORDIC arctangent chain.
`timescale 1ns / 1ps
module qte_cordic_cell import qte_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic    clk,
	input  logic    en,
	input  cordic_t d,
	output cordic_t q
);
	localparam logic signed [ZW-1:0] ANGLE = arc(STEP);

	logic signed [XW-1:0] dx, dy;
	assign dx = d.y >>> STEP;
	assign dy = d.x >>> STEP;

	always_ff @(posedge clk) begin
		if (en) begin
			if (d.y > 0) begin
				q.x <= d.x + dx;
				q.y <= d.y - dy;
				q.z <= d.z + ANGLE;
			end else if (d.y < 0) begin
				q.x <= d.x - dx;
				q.y <= d.y + dy;
				q.z <= d.z - ANGLE;
			end else begin
				q <= d;
			end
		end
	end
endmodule

@@ sv/quaternion_to_euler_angles.sv @@
// Top level: ZYX Euler angles from a Q14 quaternion, fully pipelined.
`timescale 1ns / 1ps
// Takes one quaternion per clock unless the pipe is stalled and returns roll, pitch
// and yaw in hundredths of a degree, one result per input, in order. The stages are
// the products, the pitch term and its square, 29 square-root cells for the
// pitch cosine, one quadrant fold, 28 CORDIC cells (three rows in lockstep) and
// the rounding output register. The whole pipe advances whenever the output
// register is empty or being read, so throughput is one item per cycle.
module quaternion_to_euler_angles import qte_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	qte_in_if.sink   sample,
	qte_out_if.source angles
);
	localparam int NSTG = 3 + ROOT_STEPS + 1 + STEPS;

	logic en;
	logic [NSTG-1:0] vld_q;
	logic out_vld_q;

	assign en = !out_vld_q || angles.ready;
	assign sample.ready = en;

	// stage 1: products
	logic signed [PW-1:0] ri_s1, jk_s1, ii_s1, jj_s1, rj_s1, ki_s1, rk_s1, ij_s1, kk_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			ri_s1 <= sample.q_real * sample.q_i;
			jk_s1 <= sample.q_j * sample.q_k;
			ii_s1 <= sample.q_i * sample.q_i;
			jj_s1 <= sample.q_j * sample.q_j;
			rj_s1 <= sample.q_real * sample.q_j;
			ki_s1 <= sample.q_k * sample.q_i;
			rk_s1 <= sample.q_real * sample.q_k;
			ij_s1 <= sample.q_i * sample.q_j;
			kk_s1 <= sample.q_k * sample.q_k;
		end
	end

	// stage 2: product sums, pitch term clamped to +-1.0
	logic signed [XW-1:0] sp_raw;
	args_t args_s2, args_s3;
	assign sp_raw = (XW'(rj_s1) - XW'(ki_s1)) <<< 1;
	always_ff @(posedge clk) begin
		if (en) begin
			args_s2.sr <= (XW'(ri_s1) + XW'(jk_s1)) <<< 1;
			args_s2.cr <= ONE_Q28 - ((XW'(ii_s1) + XW'(jj_s1)) <<< 1);
			args_s2.sy <= (XW'(rk_s1) + XW'(ij_s1)) <<< 1;
			args_s2.cy <= ONE_Q28 - ((XW'(jj_s1) + XW'(kk_s1)) <<< 1);
			if (sp_raw > ONE_Q28)
				args_s2.sp <= SW'(ONE_Q28);
			else if (sp_raw < -ONE_Q28)
				args_s2.sp <= SW'(-ONE_Q28);
			else
				args_s2.sp <= SW'(sp_raw);
		end
	end

	// stage 3: radicand 1 - sp^2 in Q56
	logic signed [2*SW-1:0] sq;
	logic [VW-1:0] v_s3;
	assign sq = args_s2.sp * args_s2.sp;
	always_ff @(posedge clk) begin
		if (en) begin
			v_s3    <= VW'(60'sh100000000000000 - sq);
			args_s3 <= args_s2;
		end
	end

	// square-root cells, with the other arguments riding alongside
	logic [VW-1:0] v_c [ROOT_STEPS+1];
	logic [RW-1:0] r_c [ROOT_STEPS+1];
	args_t arg_d [ROOT_STEPS+1];
	assign v_c[0]   = v_s3;
	assign r_c[0]   = '0;
	assign arg_d[0] = args_s3;

	for (genvar n = 0; n < ROOT_STEPS; n++) begin : g_root
		qte_root_cell #(.STEP(n)) u_cell (
			.clk  (clk),
			.en   (en),
			.v_in (v_c[n]),
			.r_in (r_c[n]),
			.v_out(v_c[n+1]),
			.r_out(r_c[n+1])
		);
		always_ff @(posedge clk) begin
			if (en)
				arg_d[n+1] <= arg_d[n];
		end
	end

	// quadrant fold, then three CORDIC rows: 0 roll, 1 pitch, 2 yaw
	cordic_t row [3][STEPS+1];
	always_ff @(posedge clk) begin
		if (en) begin
			row[0][0] <= pre_rotate(arg_d[ROOT_STEPS].sr, arg_d[ROOT_STEPS].cr);
			row[1][0] <= pre_rotate(XW'(arg_d[ROOT_STEPS].sp),
				signed'(XW'(r_c[ROOT_STEPS])));
			row[2][0] <= pre_rotate(arg_d[ROOT_STEPS].sy, arg_d[ROOT_STEPS].cy);
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_row
		for (genvar n = 0; n < STEPS; n++) begin : g_step
			qte_cordic_cell #(.STEP(n)) u_cell (
				.clk(clk),
				.en (en),
				.d  (row[c][n]),
				.q  (row[c][n+1])
			);
		end
	end

	// round to cdeg
	logic signed [ZW:0]   zr [3];
	logic signed [ZW-16:0] cd [3];
	for (genvar c = 0; c < 3; c++) begin : g_round
		assign zr[c] = (ZW+1)'(row[c][STEPS].z) + (ZW+1)'(32768);
		assign cd[c] = (ZW-15)'(zr[c] >>> 16);
	end

	logic signed [15:0] roll_q;
	logic signed [14:0] pitch_q;
	logic        [15:0] yaw_q;
	logic signed [15:0] yaw_c;
	logic signed [16:0] yaw_w;

	always_comb begin
		if (cd[2] > 17'sd18000)
			yaw_c = 16'sd18000;
		else if (cd[2] < -17'sd18000)
			yaw_c = -16'sd18000;
		else
			yaw_c = 16'(cd[2]);
		yaw_w = 17'(yaw_c);
		if (yaw_w < 0)
			yaw_w = yaw_w + 17'sd36000;
		if (yaw_w >= 17'sd36000)
			yaw_w = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (cd[0] > 17'sd18000)
				roll_q <= 16'sd18000;
			else if (cd[0] < -17'sd18000)
				roll_q <= -16'sd18000;
			else
				roll_q <= 16'(cd[0]);
			if (cd[1] > 17'sd9000)
				pitch_q <= 15'sd9000;
			else if (cd[1] < -17'sd9000)
				pitch_q <= -15'sd9000;
			else
				pitch_q <= 15'(cd[1]);
			yaw_q <= 16'(yaw_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[NSTG-2:0], sample.valid};
			out_vld_q <= vld_q[NSTG-1];
		end
	end

	assign angles.valid      = out_vld_q;
	assign angles.roll_cdeg  = roll_q;
	assign angles.pitch_cdeg = pitch_q;
	assign angles.yaw_cdeg   = yaw_q;

	// stalls only come from a held, unread result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (out_vld_q && !angles.ready))
		else $error("pipe stalled without a pending result");
	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (yaw_q < 16'd36000))
		else $error("yaw out of range");
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (pitch_q <= 15'sd9000 && pitch_q >= -15'sd9000))
		else $error("pitch out of range");
	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (roll_q <= 16'sd18000 && roll_q >= -16'sd18000))
		else $error("roll out of range");
endmodule

@@ dv/qte_checker.sv @@
// Watches both channels, predicts Euler angles per quaternion and compares results.
`timescale 1ns / 1ps
module qte_checker (
	input  logic clk,
	input  logic arst_n,
	qte_in_if    sample,
	qte_out_if   angles,
	output int   fail_count,
	output int   pending
);
	typedef struct {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic        [15:0] yaw;
	} euler_t;

	euler_t angle_q[$];

	// atan(2^-n) in 2^-16 cdeg
	localparam longint ATAN_LUT [28] = '{
		294912000, 174096719, 91987925, 46694507, 23437865, 11729858,
		5866610, 2933484, 1466766, 733385, 366693, 183347, 91673, 45837,
		22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3};
	localparam longint UNIT_Q28 = 64'sd1 << 28;
	localparam longint RIGHT_ANGLE = 64'sd9000 << 16;

	function automatic longint vector_angle(longint y, longint x);
		longint z, t, dx, dy;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = RIGHT_ANGLE;
			end else begin
				t = x; x = -y; y = t; z = -RIGHT_ANGLE;
			end
		end
		for (int n = 0; n < 28; n++) begin
			dx = y >>> n;
			dy = x >>> n;
			if (y > 0) begin
				x += dx; y -= dy; z += ATAN_LUT[n];
			end else if (y < 0) begin
				x -= dx; y += dy; z -= ATAN_LUT[n];
			end
		end
		return z;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint sat(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint cdeg(longint z);
		return (z + 32768) >>> 16;
	endfunction

	function automatic euler_t predict_euler(logic signed [15:0] qr, logic signed [15:0] qi,
			logic signed [15:0] qj, logic signed [15:0] qk);
		longint r, i, j, k, s, c, roll, pitch, yaw;
		euler_t e;
		r = qr; i = qi; j = qj; k = qk;
		s = 2 * (r * i + j * k);
		c = UNIT_Q28 - 2 * (i * i + j * j);
		roll = sat(cdeg(vector_angle(s, c)), -18000, 18000);
		s = sat(2 * (r * j - k * i), -UNIT_Q28, UNIT_Q28);
		c = longint'(floor_sqrt((64'd1 << 56) - longint'(s * s)));
		pitch = sat(cdeg(vector_angle(s, c)), -9000, 9000);
		s = 2 * (r * k + i * j);
		c = UNIT_Q28 - 2 * (j * j + k * k);
		yaw = sat(cdeg(vector_angle(s, c)), -18000, 18000);
		if (yaw < 0) yaw += 36000;
		if (yaw >= 36000) yaw = 0;
		e.roll = roll[15:0];
		e.pitch = pitch[14:0];
		e.yaw = yaw[15:0];
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count <= 0;
			pending = angle_q.size();
		end else begin
			if (sample.valid && sample.ready)
				angle_q.push_back(predict_euler(sample.q_real, sample.q_i, sample.q_j,
					sample.q_k));
			if (angles.valid && angles.ready) begin
				if (angle_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected result transaction");
					fail_count <= fail_count + 1;
				end else begin
					euler_t e;
					e = angle_q.pop_front();
					if (e.roll !== angles.roll_cdeg || e.pitch !== angles.pitch_cdeg
							|| e.yaw !== angles.yaw_cdeg) begin
						if (fail_count < 10)
							$display("mismatch: exp r=%0d p=%0d y=%0d got r=%0d p=%0d y=%0d",
								e.roll, e.pitch, e.yaw, angles.roll_cdeg,
								angles.pitch_cdeg, angles.yaw_cdeg);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending = angle_q.size();
		end
	end
endmodule

@@ dv/tb_quaternion_to_euler_angles.sv @@
// Testbench top: quaternion stimulus, output back-pressure and the verdict.
`timescale 1ns / 1ps
module tb_quaternion_to_euler_angles;
	logic clk = 0;
	logic arst_n = 0;
	int   fail_count, pending;
	int   idle_cycles = 0;
	bit   calm = 0;

	qte_in_if  sample();
	qte_out_if angles();

	quaternion_to_euler_angles DUT (.clk(clk), .arst_n(arst_n), .sample(sample),
		.angles(angles));
	qte_checker u_checker (.clk(clk), .arst_n(arst_n), .sample(sample), .angles(angles),
		.fail_count(fail_count), .pending(pending));

	always #6 clk = ~clk;

	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (calm || p < 60) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic int rand_comp();
		return int'($urandom_range(32768)) - 16384;
	endfunction

	task automatic send_quat(int r, int i, int j, int k);
		repeat (gap_len()) @(negedge clk);
		sample.valid = 1'b1;
		sample.q_real = 16'(r);
		sample.q_i = 16'(i);
		sample.q_j = 16'(j);
		sample.q_k = 16'(k);
		do @(posedge clk); while (!sample.ready);
		@(negedge clk);
		sample.valid = 1'b0;
	endtask

	task automatic send_unit();
		real c[4], n;
		int v[4];
		n = 0;
		for (int m = 0; m < 4; m++) begin
			c[m] = rand_comp();
			n += c[m] * c[m];
		end
		if (n == 0) n = 1;
		n = $sqrt(n);
		for (int m = 0; m < 4; m++) begin
			v[m] = $rtoi(c[m] / n * 16384.0 + (c[m] < 0 ? -0.5 : 0.5));
			if (v[m] > 16384) v[m] = 16384;
			if (v[m] < -16384) v[m] = -16384;
		end
		send_quat(v[0], v[1], v[2], v[3]);
	endtask

	// output back-pressure
	initial begin
		angles.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (gap_len() == 0) begin
				angles.ready = 1'b1;
			end else begin
				angles.ready = 1'b0;
				repeat (gap_len()) @(negedge clk);
				angles.ready = 1'b1;
			end
		end
	end

	// no-progress watchdog
	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (angles.valid && angles.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 3000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		sample.valid = 1'b0;
		sample.q_real = '0;
		sample.q_i = '0;
		sample.q_j = '0;
		sample.q_k = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send_quat(16384, 0, 0, 0);
		send_quat(-16384, 0, 0, 0);
		send_quat(0, 16384, 0, 0);
		send_quat(0, 0, 16384, 0);
		send_quat(0, 0, 0, 16384);
		send_quat(0, 0, 0, -16384);
		send_quat(0, 0, 0, 0);
		send_quat(16384, 16384, 16384, 16384);
		send_quat(-16384, -16384, -16384, -16384);
		send_quat(16384, -16384, 16384, -16384);
		// gimbal lock, pitch term near and beyond the clamp
		send_quat(11585, 0, 11585, 0);
		send_quat(11585, 0, -11585, 0);
		send_quat(16384, 0, 16384, 0);
		send_quat(-16384, 16384, 16384, 16384);
		// both atan2 arguments zero, roll then yaw
		send_quat(0, 8192, 8192, 0);
		send_quat(5000, -5000, 8192, 8192);
		// yaw just below zero wraps up, just above zero stays
		send_quat(16384, 0, 0, -1);
		send_quat(16384, 0, 0, 1);
		send_quat(-16384, 0, 0, 1);
		send_quat(0, 16384, 0, 1);
		send_quat(0, 16384, 0, -1);
		send_quat(16383, -16383, 0, 0);

		for (int n = 0; n < 1650; n++) begin
			if (n % 200 == 0) calm = ($urandom_range(2) == 0);
			if ($urandom_range(9) < 8) send_unit();
			else send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
		end
		calm = 0;

		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
